// ----- rtl/hsv_to_rgb_convert_assert.svh -----
// Assertion macros for the HSV to RGB converter.
// Included by hsv_to_rgb_convert.sv; relies on no other file.
`ifndef HSV_TO_RGB_CONVERT_ASSERT_SVH
`define HSV_TO_RGB_CONVERT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSV_ASSERT_NOW(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSV_ASSERT_NEXT(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
// Shared constants and types for the HSV to RGB converter.
// No dependencies; used by hsv2rgb_front, hsv2rgb_chan and the top level.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_MAX     = 5760;     // 360 degrees in 1/16 degree
  localparam int PCT_MAX     = 1600;     // 100 percent in 1/16 percent
  localparam int SECTOR      = 960;      // 60 degrees in 1/16 degree
  localparam int K_FULL      = 1536000;  // PCT_MAX * SECTOR
  localparam int DIVISOR     = 9375;     // PCT_MAX^2 * SECTOR / 2^18
  localparam int PRE_SHIFT   = 18;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_M     = 458129;   // floor(2^32 / DIVISOR)

  localparam int PCT_W  = 11;
  localparam int DIST_W = 10;
  localparam int K_W    = 21;
  localparam int P_W    = 32;
  localparam int Q_W    = 22;
  localparam int M_W    = 19;
  localparam int CH_W   = 8;

  // Per-stage load enables for the channel datapath.
  typedef struct packed {
    logic ld_k;
    logic ld_p;
    logic ld_q;
    logic ld_e;
    logic ld_o;
  } pipe_ctl_t;

endpackage

// ----- rtl/hsv_to_rgb_convert.sv -----
// HSV to RGB color converter, six register stages, one color per clock cycle while the output is not stalled.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_chan and hsv_to_rgb_convert_assert.svh.
//
// Takes one color (hue in 1/16 degree, saturation and value in 1/16 percent) per
// transaction and returns red, green and blue bytes truncated toward zero, plus an
// in_range flag; a color outside 0..360 degrees or 0..100 percent gives zero channels
// and a cleared flag. The input transaction loads the first of six register stages,
// and the block sustains one transaction per cycle while out_stall is low. Each stage
// holds a valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up under output stall and new colors keep entering until all six stages
// are full; the stage count is set by the two multiplies of the channel scaling and
// the reciprocal division by the constant denominator with its one-step correction.
`timescale 1ns / 1ps
`include "hsv_to_rgb_convert_assert.svh"

module hsv_to_rgb_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [13:0] hue,
  input  logic signed [11:0] saturation,
  input  logic signed [11:0] brightness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               in_range
);

  localparam int NSTG = 6;

  logic [NSTG-1:0]                    vld;
  logic [NSTG-1:0]                    en;
  logic [NSTG-1:1]                    rng;
  hsv2rgb_pkg::pipe_ctl_t             ctl;
  logic [hsv2rgb_pkg::PCT_W-1:0]      sat_q;
  logic [hsv2rgb_pkg::PCT_W-1:0]      val_q;
  logic [hsv2rgb_pkg::DIST_W-1:0]     dist_r;
  logic [hsv2rgb_pkg::DIST_W-1:0]     dist_g;
  logic [hsv2rgb_pkg::DIST_W-1:0]     dist_b;
  logic                               rng_q;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];
  assign in_range  = rng[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rng[1] <= rng_q;
    end
    for (int i = 2; i < NSTG; i++) begin
      if (en[i]) begin
        rng[i] <= rng[i-1];
      end
    end
  end

  assign ctl.ld_k = en[1];
  assign ctl.ld_p = en[2];
  assign ctl.ld_q = en[3];
  assign ctl.ld_e = en[4];
  assign ctl.ld_o = en[5];

  hsv2rgb_front u_front (
    .clk        (clk),
    .ld         (en[0]),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sat_q      (sat_q),
    .val_q      (val_q),
    .dist_r     (dist_r),
    .dist_g     (dist_g),
    .dist_b     (dist_b),
    .rng_q      (rng_q)
  );

  hsv2rgb_chan u_red (
    .clk   (clk),
    .ctl   (ctl),
    .sat   (sat_q),
    .val   (val_q),
    .dterm (dist_r),
    .chan  (red)
  );

  hsv2rgb_chan u_green (
    .clk   (clk),
    .ctl   (ctl),
    .sat   (sat_q),
    .val   (val_q),
    .dterm (dist_g),
    .chan  (green)
  );

  hsv2rgb_chan u_blue (
    .clk   (clk),
    .ctl   (ctl),
    .sat   (sat_q),
    .val   (val_q),
    .dterm (dist_b),
    .chan  (blue)
  );

  `HSV_ASSERT_NOW(a_zero_when_out_of_range, clk, rst,
    out_valid && !in_range, (red == 8'd0) && (green == 8'd0) && (blue == 8'd0),
    "out-of-range color produced nonzero channel")

  `HSV_ASSERT_NOW(a_stall_only_when_full, clk, rst,
    in_stall, (&vld) && out_stall,
    "input stalled while the pipeline holds a bubble")

  `HSV_ASSERT_NEXT(a_accept_fills_first_stage, clk, rst,
    in_valid && !in_stall, vld[0],
    "accepted transaction did not reach the first stage")

endmodule

// ----- rtl/hsv2rgb_front.sv -----
// First pipeline stage: range check, hue sector decode and per-channel distance.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_front (
  input  logic                                   clk,
  input  logic                                   ld,
  input  logic signed [13:0]                     hue,
  input  logic signed [11:0]                     saturation,
  input  logic signed [11:0]                     brightness,
  output logic [hsv2rgb_pkg::PCT_W-1:0]          sat_q,
  output logic [hsv2rgb_pkg::PCT_W-1:0]          val_q,
  output logic [hsv2rgb_pkg::DIST_W-1:0]         dist_r,
  output logic [hsv2rgb_pkg::DIST_W-1:0]         dist_g,
  output logic [hsv2rgb_pkg::DIST_W-1:0]         dist_b,
  output logic                                   rng_q
);

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } sector_t;

  localparam int S = hsv2rgb_pkg::SECTOR;

  logic                                 ok;
  logic [12:0]                          hu;
  sector_t                              sec;
  logic [12:0]                          base;
  logic [12:0]                          hm_full;
  logic [10:0]                          hm;
  logic [10:0]                          dist_full;
  logic [hsv2rgb_pkg::DIST_W-1:0]       hdist;
  logic [hsv2rgb_pkg::DIST_W-1:0]       d_zero;
  logic [hsv2rgb_pkg::DIST_W-1:0]       dist_r_next;
  logic [hsv2rgb_pkg::DIST_W-1:0]       dist_g_next;
  logic [hsv2rgb_pkg::DIST_W-1:0]       dist_b_next;

  assign ok = (hue >= 0) && (hue <= hsv2rgb_pkg::HUE_MAX) &&
              (saturation >= 0) && (saturation <= hsv2rgb_pkg::PCT_MAX) &&
              (brightness >= 0) && (brightness <= hsv2rgb_pkg::PCT_MAX);

  assign hu = hue[12:0];

  always_comb begin
    if (hu < 13'(S)) begin
      sec = SEC_RY;
    end else if (hu < 13'(2 * S)) begin
      sec = SEC_YG;
    end else if (hu < 13'(3 * S)) begin
      sec = SEC_GC;
    end else if (hu < 13'(4 * S)) begin
      sec = SEC_CB;
    end else if (hu < 13'(5 * S)) begin
      sec = SEC_BM;
    end else begin
      sec = SEC_MR;  // includes exactly 360 degrees
    end
  end

  // Hue within its 120-degree pair; 360 degrees lands on 1920 and gives X of zero.
  always_comb begin
    unique case (sec)
      SEC_RY, SEC_YG: base = 13'd0;
      SEC_GC, SEC_CB: base = 13'(2 * S);
      SEC_BM, SEC_MR: base = 13'(4 * S);
      default:        base = 13'd0;
    endcase
  end

  assign hm_full   = hu - base;
  assign hm        = hm_full[10:0];
  assign dist_full = (hm >= 11'(S)) ? (hm - 11'(S)) : (11'(S) - hm);
  assign hdist     = dist_full[hsv2rgb_pkg::DIST_W-1:0];
  assign d_zero    = hsv2rgb_pkg::DIST_W'(S);

  // Distance term per channel: 0 selects C, SECTOR selects the zero part, hdist selects X.
  always_comb begin
    unique case (sec)
      SEC_RY: begin
        dist_r_next = '0;     dist_g_next = hdist;  dist_b_next = d_zero;
      end
      SEC_YG: begin
        dist_r_next = hdist;  dist_g_next = '0;     dist_b_next = d_zero;
      end
      SEC_GC: begin
        dist_r_next = d_zero; dist_g_next = '0;     dist_b_next = hdist;
      end
      SEC_CB: begin
        dist_r_next = d_zero; dist_g_next = hdist;  dist_b_next = '0;
      end
      SEC_BM: begin
        dist_r_next = hdist;  dist_g_next = d_zero; dist_b_next = '0;
      end
      SEC_MR: begin
        dist_r_next = '0;     dist_g_next = d_zero; dist_b_next = hdist;
      end
      default: begin
        dist_r_next = '0;     dist_g_next = '0;     dist_b_next = '0;
      end
    endcase
  end

  // Out of range: force saturation and value to zero so every channel comes out zero.
  always_ff @(posedge clk) begin
    if (ld) begin
      sat_q  <= ok ? saturation[hsv2rgb_pkg::PCT_W-1:0] : '0;
      val_q  <= ok ? brightness[hsv2rgb_pkg::PCT_W-1:0] : '0;
      dist_r <= dist_r_next;
      dist_g <= dist_g_next;
      dist_b <= dist_b_next;
      rng_q  <= ok;
    end
  end

endmodule

// ----- rtl/hsv2rgb_chan.sv -----
// Five-stage channel datapath: byte = floor(v * (K_FULL - s*d) * 255 / (1600*1600*960)).
// Depends on hsv2rgb_pkg; instanced once per color channel by the top level.
`timescale 1ns / 1ps

module hsv2rgb_chan (
  input  logic                              clk,
  input  hsv2rgb_pkg::pipe_ctl_t            ctl,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     sat,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]     val,
  input  logic [hsv2rgb_pkg::DIST_W-1:0]    dterm,
  output logic [hsv2rgb_pkg::CH_W-1:0]      chan
);

  localparam int KW = hsv2rgb_pkg::K_W;
  localparam int PW = hsv2rgb_pkg::P_W;
  localparam int QW = hsv2rgb_pkg::Q_W;
  localparam int CW = hsv2rgb_pkg::CH_W;
  localparam int RS = hsv2rgb_pkg::RECIP_SHIFT;
  localparam int MW = QW + hsv2rgb_pkg::M_W;
  localparam int SW = PW + CW;

  logic [KW-1:0]                   sd;
  logic [KW-1:0]                   k;
  logic [hsv2rgb_pkg::PCT_W-1:0]   val2;
  logic [PW-1:0]                   p;
  logic [SW-1:0]                   p255;
  logic [QW-1:0]                   q;
  logic [MW-1:0]                   prod;
  logic [CW-1:0]                   est;
  logic [QW-1:0]                   q5;
  logic [QW-1:0]                   back;
  logic [QW-1:0]                   rem;

  assign sd = KW'(sat) * KW'(dterm);

  always_ff @(posedge clk) begin
    if (ctl.ld_k) begin
      k    <= KW'(hsv2rgb_pkg::K_FULL) - sd;
      val2 <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_p) begin
      p <= PW'(val2) * PW'(k);
    end
  end

  // Times 255, then drop the power-of-two part of the divisor.
  assign p255 = {p, {CW{1'b0}}} - {{CW{1'b0}}, p};

  always_ff @(posedge clk) begin
    if (ctl.ld_q) begin
      q <= p255[SW-1:hsv2rgb_pkg::PRE_SHIFT];
    end
  end

  // Reciprocal estimate is exact or one low.
  assign prod = MW'(q) * MW'(hsv2rgb_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (ctl.ld_e) begin
      est <= prod[RS+CW-1:RS];
      q5  <= q;
    end
  end

  assign back = QW'(est) * QW'(hsv2rgb_pkg::DIVISOR);
  assign rem  = q5 - back;

  always_ff @(posedge clk) begin
    if (ctl.ld_o) begin
      chan <= (rem >= QW'(hsv2rgb_pkg::DIVISOR)) ? est + CW'(1) : est;
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench for hsv_to_rgb_convert: directed and random colors under random idle and stall.
// A scoreboard class predicts each color from exact integer arithmetic and checks results.
// Depends only on the RTL of hsv_to_rgb_convert.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       in_range;
} rgb_t;

typedef struct packed {
  logic signed [13:0] hue;
  logic signed [11:0] saturation;
  logic signed [11:0] brightness;
  rgb_t               rgb;
} color_entry_t;

class rgb_scoreboard;
  localparam int HUE_FULL = 5760;
  localparam int PCT_FULL = 1600;
  localparam int SIXTY    = 960;
  localparam longint unsigned DENOM = 64'd2457600000;  // 1600 * 1600 * 960

  color_entry_t rgb_due[$];
  int unsigned  errors;
  int unsigned  colors;
  int unsigned  in_range_colors;

  function new();
    errors          = 0;
    colors          = 0;
    in_range_colors = 0;
  endfunction

  function rgb_t rgb_of_hsv(logic signed [13:0] h, logic signed [11:0] s,
                            logic signed [11:0] v);
    rgb_t res;
    longint unsigned hu, su, vu, hm, hdist, cn, xn, mn, pr, pg, pb;
    res = '0;
    if (h < 0 || h > HUE_FULL || s < 0 || s > PCT_FULL || v < 0 || v > PCT_FULL)
      return res;
    hu    = longint'(h);
    su    = longint'(s);
    vu    = longint'(v);
    hm    = hu % (2 * SIXTY);
    hdist = (hm >= SIXTY) ? hm - SIXTY : SIXTY - hm;
    cn    = su * vu * SIXTY;
    xn    = su * vu * (SIXTY - hdist);
    mn    = vu * PCT_FULL * SIXTY - cn;
    // hue of exactly 360 degrees stays in the last sector
    if (hu < 1 * SIXTY) begin
      pr = cn; pg = xn; pb = 0;
    end else if (hu < 2 * SIXTY) begin
      pr = xn; pg = cn; pb = 0;
    end else if (hu < 3 * SIXTY) begin
      pr = 0;  pg = cn; pb = xn;
    end else if (hu < 4 * SIXTY) begin
      pr = 0;  pg = xn; pb = cn;
    end else if (hu < 5 * SIXTY) begin
      pr = xn; pg = 0;  pb = cn;
    end else begin
      pr = cn; pg = 0;  pb = xn;
    end
    res.red      = 8'(((pr + mn) * 255) / DENOM);
    res.green    = 8'(((pg + mn) * 255) / DENOM);
    res.blue     = 8'(((pb + mn) * 255) / DENOM);
    res.in_range = 1'b1;
    return res;
  endfunction

  function void note_color(logic signed [13:0] h, logic signed [11:0] s,
                           logic signed [11:0] v);
    color_entry_t e;
    e.hue        = h;
    e.saturation = s;
    e.brightness = v;
    e.rgb        = rgb_of_hsv(h, s, v);
    colors++;
    if (e.rgb.in_range)
      in_range_colors++;
    rgb_due.push_back(e);
  endfunction

  function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic f);
    color_entry_t e;
    if (rgb_due.size() == 0) begin
      $display("%0t: unexpected result r=%0d g=%0d b=%0d in_range=%0b", $time, r, g, b, f);
      errors++;
      return;
    end
    e = rgb_due.pop_front();
    if (r !== e.rgb.red || g !== e.rgb.green || b !== e.rgb.blue || f !== e.rgb.in_range) begin
      $display("%0t: mismatch h=%0d s=%0d v=%0d expected r=%0d g=%0d b=%0d in_range=%0b",
               $time, e.hue, e.saturation, e.brightness,
               e.rgb.red, e.rgb.green, e.rgb.blue, e.rgb.in_range);
      $display("%0t:   actual r=%0d g=%0d b=%0d in_range=%0b", $time, r, g, b, f);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return rgb_due.size();
  endfunction
endclass

module tb;
  localparam int RANDOM_COLORS = 1900;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TAIL_CYCLES   = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [13:0] hue = '0;
  logic signed [11:0] saturation = '0;
  logic signed [11:0] brightness = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               in_range;

  rgb_scoreboard sb = new();

  int          idle_pct  = 0;   // chance of a gap before a color
  int          stall_pct = 0;   // chance of starting a stall burst
  int          stall_left = 0;
  int unsigned cycles = 0;

  hsv_to_rgb_convert dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .in_range   (in_range)
  );

  always #2 clk = ~clk;

  // mostly short bursts, now and then a long one
  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [11:0] pct_edge();
    case ($urandom_range(0, 5))
      0: return 12'sd0;
      1: return 12'sd1;
      2: return 12'sd1599;
      3: return 12'sd1600;
      4: return 12'sd1601;
      default: return -12'sd1;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL hsv_to_rgb_convert");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_rgb(red, green, blue, in_range);
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left = burst_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one color, hold it until the transaction completes, then record it.
  task automatic send_color(logic signed [13:0] h, logic signed [11:0] s,
                            logic signed [11:0] v);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (in_stall);
    sb.note_color(h, s, v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_color();
    int kind;
    logic signed [13:0] h;
    logic signed [11:0] s, v;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      h = 14'($urandom_range(0, 5760));
      s = 12'($urandom_range(0, 1600));
      v = 12'($urandom_range(0, 1600));
    end else if (kind < 82) begin
      // sector boundaries and percent limits, one step either side
      h = 14'($urandom_range(0, 6) * 960 + $urandom_range(0, 2) - 1);
      s = pct_edge();
      v = pct_edge();
    end else begin
      h = 14'($urandom());
      s = 12'($urandom());
      v = 12'($urandom());
    end
    send_color(h, s, v);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: sector edges, exact 360, range limits, extremes of the fields
    send_color(14'sd0,     12'sd1600, 12'sd1600);
    send_color(14'sd959,   12'sd1600, 12'sd1600);
    send_color(14'sd960,   12'sd1600, 12'sd1600);
    send_color(14'sd1919,  12'sd1600, 12'sd1600);
    send_color(14'sd1920,  12'sd1600, 12'sd1600);
    send_color(14'sd2880,  12'sd1600, 12'sd1600);
    send_color(14'sd3840,  12'sd1600, 12'sd1600);
    send_color(14'sd4800,  12'sd1600, 12'sd1600);
    send_color(14'sd5759,  12'sd1600, 12'sd1600);
    send_color(14'sd5760,  12'sd1600, 12'sd1600);
    send_color(14'sd5760,  12'sd800,  12'sd1200);
    send_color(14'sd2000,  12'sd0,    12'sd1600);
    send_color(14'sd2000,  12'sd1600, 12'sd0);
    send_color(14'sd0,     12'sd0,    12'sd0);
    send_color(14'sd1234,  12'sd777,  12'sd1111);
    send_color(-14'sd1,    12'sd800,  12'sd800);
    send_color(14'sd5761,  12'sd800,  12'sd800);
    send_color(-14'sd8192, 12'sd800,  12'sd800);
    send_color(14'sd8191,  12'sd800,  12'sd800);
    send_color(14'sd3000,  -12'sd1,   12'sd800);
    send_color(14'sd3000,  12'sd1601, 12'sd800);
    send_color(14'sd3000,  12'sd2047, -12'sd2048);
    send_color(14'sd3000,  -12'sd2048, 12'sd2047);
    send_color(14'sd3000,  12'sd800,  12'sd1601);
    send_color(14'sd3000,  12'sd800,  -12'sd1);

    for (int i = 0; i < RANDOM_COLORS; i++) begin
      // step through pacing phases, including stretches with no idling at all
      if (i % 200 == 0) begin
        case ((i / 200) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 30; stall_pct = 30; end
          2: begin idle_pct = 10; stall_pct = 60; end
          default: begin idle_pct = 60; stall_pct = 10; end
        endcase
      end
      if (i == RANDOM_COLORS / 2)
        drain_results();
      send_random_color();
    end

    drain_results();
    $display("Converted %0d colors, %0d in range and %0d out of range,",
             sb.colors, sb.in_range_colors, sb.colors - sb.in_range_colors);
    $display("with random input gaps and output stalls; %0d errors.", sb.errors);
    if (sb.errors == 0)
      $display("PASS hsv_to_rgb_convert");
    else
      $display("FAIL hsv_to_rgb_convert");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_chan.sv
rtl/hsv_to_rgb_convert.sv
sim/tb.sv
